>>> rtl/w2s_pkg.sv
// Shared constants and types for the world-to-screen projection block.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps
package w2s_pkg;

   localparam int MAT_N    = 16;
   localparam int MAT_W    = 4;
   localparam int COORD_W  = 32;
   localparam int PROD_W   = 2 * COORD_W;
   localparam int FRAC_W   = 16;
   localparam int CLIP_W   = 50;
   localparam int SIZE_W   = 16;
   localparam int HALF_W   = SIZE_W - 1;
   localparam int NUM_W    = 64;
   localparam int QUO_W    = 33;
   localparam int NLO_W    = QUO_W - FRAC_W;
   localparam int SUM_W    = QUO_W + 2;
   localparam int CSR_IDX_W = 8;

   localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(6554);

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_PROJECT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = CSR_IDX_W'(1);

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);

   typedef struct packed {
      logic                valid;
      logic                visible;
      logic                neg;
      logic                ovf;
      logic [COORD_W-1:0]  base;
   } w2s_meta_type;

endpackage

>>> rtl/w2s_clip.sv
// Coefficient store and clip-space transform: products, then partial sums, then totals.
// Depends on w2s_pkg.
`timescale 1ns / 1ps
module w2s_clip
   import w2s_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      load_we,
   input  logic [MAT_W-1:0]          load_idx,
   input  logic [COORD_W-1:0]        load_val,
   input  logic                      proj_valid,
   input  logic [COORD_W-1:0]        pos_x,
   input  logic [COORD_W-1:0]        pos_y,
   input  logic [COORD_W-1:0]        pos_z,
   output logic                      out_valid,
   output logic signed [CLIP_W-1:0]  clip_x,
   output logic signed [CLIP_W-1:0]  clip_y,
   output logic signed [CLIP_W-1:0]  clip_w
);

   localparam int ROWS = 3;
   localparam int TERMS = 3;

   logic [COORD_W-1:0]        mat_ff [MAT_N];
   logic signed [PROD_W-1:0]  prod_in [ROWS*TERMS];
   logic signed [PROD_W-1:0]  prod_ff [ROWS*TERMS];
   logic [COORD_W-1:0]        trans_ff [ROWS];
   logic                      v1_ff, v2_ff, v3_ff;
   logic signed [CLIP_W-1:0]  a_ff [ROWS];
   logic signed [CLIP_W-1:0]  b_ff [ROWS];
   logic signed [CLIP_W-1:0]  a_in [ROWS];
   logic signed [CLIP_W-1:0]  b_in [ROWS];
   logic signed [CLIP_W-1:0]  sum_ff [ROWS];
   logic [1:0]                row_base [ROWS];
   logic [COORD_W-1:0]        pos [TERMS];

   assign row_base[0] = 2'd0;
   assign row_base[1] = 2'd1;
   assign row_base[2] = 2'd3;
   assign pos[0] = pos_x;
   assign pos[1] = pos_y;
   assign pos[2] = pos_z;

   function automatic logic signed [CLIP_W-1:0] floor_q(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p >>> FRAC_W;
      return s[CLIP_W-1:0];
   endfunction

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         for (int j = 0; j < TERMS; j++) begin
            prod_in[r*TERMS+j] = $signed(pos[j]) *
                                 $signed(mat_ff[MAT_W'(row_base[r]) + MAT_W'(4*j)]);
         end
         a_in[r] = floor_q(prod_ff[r*TERMS]) + floor_q(prod_ff[r*TERMS+1]);
         b_in[r] = floor_q(prod_ff[r*TERMS+2]) +
                   CLIP_W'($signed(trans_ff[r]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_N; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (load_we) begin
         mat_ff[load_idx] <= load_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= proj_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ROWS*TERMS; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         for (int r = 0; r < ROWS; r++) begin
            trans_ff[r] <= mat_ff[MAT_W'(row_base[r]) + MAT_W'(12)];
            a_ff[r]     <= a_in[r];
            b_ff[r]     <= b_in[r];
            sum_ff[r]   <= a_ff[r] + b_ff[r];
         end
      end
   end

   assign out_valid = v3_ff;
   assign clip_x    = sum_ff[0];
   assign clip_y    = sum_ff[1];
   assign clip_w    = sum_ff[2];

endmodule

>>> rtl/w2s_div.sv
// Pipelined restoring divider: one quotient bit per stage of floor(num * 2^16 / den).
// Carries the per-word side data alongside. Depends on w2s_pkg.
`timescale 1ns / 1ps
module w2s_div
   import w2s_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic [NUM_W-1:0]     num,
   input  logic [CLIP_W-1:0]    den,
   input  w2s_meta_type         meta_in,
   output logic [QUO_W-1:0]     quo,
   output w2s_meta_type         meta_out
);

   logic [CLIP_W-1:0]   r_ff   [QUO_W+1];
   logic [QUO_W-1:0]    q_ff   [QUO_W+1];
   logic [NLO_W-1:0]    nlo_ff [QUO_W+1];
   logic [CLIP_W-1:0]   den_ff [QUO_W+1];
   w2s_meta_type        meta_ff [QUO_W+1];
   logic [CLIP_W-1:0]   r_in   [QUO_W+1];
   logic [QUO_W-1:0]    q_in   [QUO_W+1];
   logic [CLIP_W-1:0]   r0;
   w2s_meta_type        meta0;

   always_comb begin
      logic [CLIP_W-1:0] t;
      logic              nb;
      r0 = CLIP_W'(num >> NLO_W);
      meta0 = meta_in;
      meta0.ovf = (r0 >= den);
      r_in[0] = r0;
      q_in[0] = '0;
      for (int k = 1; k <= QUO_W; k++) begin
         nb = nlo_ff[k-1][NLO_W-1];
         t  = {r_ff[k-1][CLIP_W-2:0], nb};
         if (t >= den_ff[k-1]) begin
            r_in[k] = t - den_ff[k-1];
            q_in[k] = {q_ff[k-1][QUO_W-2:0], 1'b1};
         end else begin
            r_in[k] = t;
            q_in[k] = {q_ff[k-1][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QUO_W; k++) begin
            meta_ff[k] <= '0;
         end
      end else if (en) begin
         meta_ff[0] <= meta0;
         for (int k = 1; k <= QUO_W; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= r_in[0];
         q_ff[0]   <= q_in[0];
         nlo_ff[0] <= num[NLO_W-1:0];
         den_ff[0] <= den;
         for (int k = 1; k <= QUO_W; k++) begin
            r_ff[k]   <= r_in[k];
            q_ff[k]   <= q_in[k];
            nlo_ff[k] <= {nlo_ff[k-1][NLO_W-2:0], 1'b0};
            den_ff[k] <= den_ff[k-1];
         end
      end
   end

   assign quo      = q_ff[QUO_W];
   assign meta_out = meta_ff[QUO_W];

endmodule

>>> rtl/world_to_screen_projection.sv
// Top level of the world-to-screen projection pipeline.
// Depends on w2s_pkg, w2s_clip and w2s_div.
//
// Input words (req_) either load one column-major Q16.16 matrix coefficient
// (req_func = 0) or project a world point (req_func = 1). Loads produce no
// output word; each project word produces exactly one rsp_ word holding
// rsp_visible, rsp_screen_x and rsp_screen_y in Q16.16 pixels.
// The csr_ port writes the viewport width (index 0) and height (index 1);
// other indexes are ignored. It is always ready.
// On its way to rsp_valid the word crosses three clip-transform stages, one
// scaling stage, the 34-stage divider and the output register, and the first
// of these loads at the accepting edge.
// Throughput is one word per cycle while rsp_ready does not stall the pipeline.
// A load takes effect for any project word accepted after it.
// Reset clears the matrix to zero, sets the viewport to 1920 by 1080 and
// empties the pipeline. When the receiver holds rsp_ready low with a word
// waiting, the whole pipeline freezes and req_ready drops in the same
// cycle; no word is lost or repeated.
`timescale 1ns / 1ps
module world_to_screen_projection
   import w2s_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [MAT_W-1:0]      req_coef_index,
   input  logic [COORD_W-1:0]    req_coef_value,
   input  logic [COORD_W-1:0]    req_pos_x,
   input  logic [COORD_W-1:0]    req_pos_y,
   input  logic [COORD_W-1:0]    req_pos_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_visible,
   output logic [COORD_W-1:0]    rsp_screen_x,
   output logic [COORD_W-1:0]    rsp_screen_y,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0]     csr_wdata
);

   logic                       en;
   logic                       accept;
   logic [SIZE_W-1:0]          width_ff, height_ff;
   logic                       clip_valid;
   logic signed [CLIP_W-1:0]   clip_x, clip_y, clip_w;
   logic [HALF_W-1:0]          half_w, half_h;
   logic [CLIP_W-1:0]          mag_x, mag_y;
   logic [NUM_W-1:0]           num_x_ff, num_y_ff;
   logic [CLIP_W-1:0]          den_ff;
   w2s_meta_type               mx_ff, my_ff, mx_out, my_out;
   logic [QUO_W-1:0]           quo_x, quo_y;
   logic                       rsp_valid_ff, rsp_visible_ff;
   logic [COORD_W-1:0]         sx_ff, sy_ff;
   logic                       vis;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   w2s_clip u_clip (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .load_we    (accept && (req_func == FUNC_LOAD)),
      .load_idx   (req_coef_index),
      .load_val   (req_coef_value),
      .proj_valid (accept && (req_func == FUNC_PROJECT)),
      .pos_x      (req_pos_x),
      .pos_y      (req_pos_y),
      .pos_z      (req_pos_z),
      .out_valid  (clip_valid),
      .clip_x     (clip_x),
      .clip_y     (clip_y),
      .clip_w     (clip_w)
   );

   assign half_w = width_ff[SIZE_W-1:1];
   assign half_h = height_ff[SIZE_W-1:1];
   assign mag_x  = clip_x[CLIP_W-1] ? CLIP_W'(-clip_x) : CLIP_W'(clip_x);
   assign mag_y  = clip_y[CLIP_W-1] ? CLIP_W'(-clip_y) : CLIP_W'(clip_y);
   assign vis    = (clip_w >= W_MIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         mx_ff <= '0;
         my_ff <= '0;
      end else if (en) begin
         mx_ff.valid   <= clip_valid;
         mx_ff.visible <= vis;
         mx_ff.neg     <= clip_x[CLIP_W-1];
         mx_ff.ovf     <= 1'b0;
         mx_ff.base    <= {1'b0, half_w, {FRAC_W{1'b0}}};
         my_ff.valid   <= clip_valid;
         my_ff.visible <= vis;
         my_ff.neg     <= !clip_y[CLIP_W-1];
         my_ff.ovf     <= 1'b0;
         my_ff.base    <= {1'b0, half_h, {FRAC_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_x_ff <= NUM_W'(half_w) * NUM_W'(mag_x);
         num_y_ff <= NUM_W'(half_h) * NUM_W'(mag_y);
         den_ff   <= clip_w;
      end
   end

   w2s_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .num      (num_x_ff),
      .den      (den_ff),
      .meta_in  (mx_ff),
      .quo      (quo_x),
      .meta_out (mx_out)
   );

   w2s_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .num      (num_y_ff),
      .den      (den_ff),
      .meta_in  (my_ff),
      .quo      (quo_y),
      .meta_out (my_out)
   );

   function automatic logic [COORD_W-1:0] finish(input w2s_meta_type m,
                                                 input logic [QUO_W-1:0] q);
      logic signed [SUM_W-1:0] s;
      if (!m.visible) begin
         return '0;
      end
      if (m.ovf) begin
         return m.neg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end
      s = m.neg ? $signed(SUM_W'(m.base)) - $signed(SUM_W'(q))
                : $signed(SUM_W'(m.base)) + $signed(SUM_W'(q));
      if (s > $signed(SUM_W'({1'b0, {(COORD_W-1){1'b1}}}))) begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
      if (s < -$signed(SUM_W'({1'b1, {(COORD_W-1){1'b0}}}))) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end
      return s[COORD_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= mx_out.valid && my_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_visible_ff <= mx_out.visible;
         sx_ff          <= finish(mx_out, quo_x);
         sy_ff          <= finish(my_out, quo_y);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_visible  = rsp_visible_ff;
   assign rsp_screen_x = sx_ff;
   assign rsp_screen_y = sy_ff;

endmodule
